// ----- rtl/dpu_pkg.sv -----
// delivery predictability update: shared types, widths and constants
// used by dpu_ctrl, dpu_dp and the top level; no dependencies
`default_nettype none

package dpu_pkg;

    localparam int FRAC_BITS = 16;
    localparam int P_W       = FRAC_BITS + 1;
    localparam int KIND_W    = 2;
    localparam int TIME_W    = 32;
    localparam int KAPPA_W   = 16;
    localparam int CFG_W     = P_W;
    localparam int CFG_IDX_W = 2;
    localparam int MS_W      = 10;
    localparam int UNITS_W   = TIME_W + MS_W;
    localparam int CNT_W     = $clog2(UNITS_W);

    localparam logic [P_W-1:0]     ONE        = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [P_W-1:0]     PENC_RST   = P_W'((3 * (2 ** FRAC_BITS)) / 4);
    localparam logic [P_W-1:0]     BETA_RST   = P_W'((2 ** FRAC_BITS) / 4);
    localparam logic [P_W-1:0]     GAMMA_RST  = P_W'((99 * (2 ** FRAC_BITS) + 50) / 100);
    localparam logic [KAPPA_W-1:0] KAPPA_RST  = KAPPA_W'(100);
    localparam logic [MS_W-1:0]    MS_PER_S   = MS_W'(1000);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_P_ENC = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_BETA  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_GAMMA = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_KAPPA = CFG_IDX_W'(3);

    // update kinds
    localparam logic [KIND_W-1:0] KIND_ENC   = KIND_W'(0);
    localparam logic [KIND_W-1:0] KIND_TRANS = KIND_W'(1);
    localparam logic [KIND_W-1:0] KIND_AGE   = KIND_W'(2);

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_ENC_MUL,
        OP_ENC_ADD,
        OP_TR_M1,
        OP_TR_M2,
        OP_TR_M3,
        OP_TR_M4,
        OP_TR_ADD,
        OP_AGE_PREP,
        OP_DIV_STEP,
        OP_POW_MUL,
        OP_POW_SQR,
        OP_AGE_FIN,
        OP_DONE_APP,
        OP_DONE_SKIP
    } t_dp_op;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_ENC_MUL,
        S_ENC_ADD,
        S_TR_M1,
        S_TR_M2,
        S_TR_M3,
        S_TR_M4,
        S_TR_ADD,
        S_AGE_PREP,
        S_DIV,
        S_POW_CHK,
        S_POW_MUL,
        S_POW_SQR,
        S_AGE_FIN,
        S_DONE_APP,
        S_DONE_SKIP
    } t_state;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              tr_ok;
        logic              kappa_zero;
        logic              div_last;
        logic              exp_zero;
        logic              exp_lsb;
        logic              exp_next_zero;
        logic              exp_next_lsb;
    } t_dp_stat;

    function automatic logic [P_W-1:0] sat_one(input logic [P_W-1:0] v);
        sat_one = (v > ONE) ? ONE : v;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/delivery_predictability_update_core.sv -----
// Delivery predictability update: top level joining dpu_ctrl and dpu_dp.
// Depends on dpu_pkg, dpu_ctrl and dpu_dp.
//
// Usage: present kind, now, prob_ab and prob_bc with start high while busy
// is low; the item is accepted at that clock edge and busy rises. One
// result per item appears on o_probability / o_applied for exactly one
// cycle with o_done high, in the cycle in which busy falls again. The
// receiver cannot hold results off, so the block never waits on it.
// An age update divides the elapsed milliseconds by kappa with radix-2
// division, then squares once per exponent bit and multiplies once per set
// bit on the single shared 17x17 multiplier; with kappa zero the division
// is left out. One item is in flight at a time; the next can be accepted in
// the cycle in which o_done is high. Configuration is written through
// i_cfg_we / i_cfg_idx / i_cfg_data with no wait; the user must write it
// only while the block is idle, as the block itself has no check for this.
// Synchronous active-low reset restores the default factors, and clears
// the probability and last update time.
`default_nettype none

module delivery_predictability_update_core import dpu_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [KIND_W-1:0]    i_kind,
    input  logic [TIME_W-1:0]    i_now,
    input  logic [P_W-1:0]       i_prob_ab,
    input  logic [P_W-1:0]       i_prob_bc,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output logic                 o_done,
    output logic [P_W-1:0]       o_probability,
    output logic                 o_applied
);

    t_dp_op   op;
    t_dp_stat stat;

    dpu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_op    (op),
        .o_busy  (busy)
    );

    dpu_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (op),
        .i_kind        (i_kind),
        .i_now         (i_now),
        .i_prob_ab     (i_prob_ab),
        .i_prob_bc     (i_prob_bc),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_stat        (stat),
        .o_done        (o_done),
        .o_probability (o_probability),
        .o_applied     (o_applied)
    );

endmodule

`default_nettype wire

// ----- rtl/dpu_ctrl.sv -----
// sequencer for the delivery predictability update
// steps the shared multiplier and divider in dpu_dp; uses dpu_pkg
`default_nettype none

module dpu_ctrl import dpu_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_dp_stat i_stat,
    output t_dp_op   o_op,
    output logic     o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_stat.kind == KIND_ENC) begin
                    n_state = S_ENC_MUL;
                end else if (i_stat.kind == KIND_TRANS) begin
                    n_state = i_stat.tr_ok ? S_TR_M1 : S_DONE_SKIP;
                end else if (i_stat.kind == KIND_AGE) begin
                    n_state = S_AGE_PREP;
                end else begin
                    n_state = S_DONE_SKIP;
                end
            end
            S_ENC_MUL:  n_state = S_ENC_ADD;
            S_ENC_ADD:  n_state = S_DONE_APP;
            S_TR_M1:    n_state = S_TR_M2;
            S_TR_M2:    n_state = S_TR_M3;
            S_TR_M3:    n_state = S_TR_M4;
            S_TR_M4:    n_state = S_TR_ADD;
            S_TR_ADD:   n_state = S_DONE_APP;
            S_AGE_PREP: n_state = i_stat.kappa_zero ? S_POW_CHK : S_DIV;
            S_DIV: begin
                if (i_stat.div_last) begin
                    n_state = S_POW_CHK;
                end
            end
            S_POW_CHK: begin
                if (i_stat.exp_zero) begin
                    n_state = S_AGE_FIN;
                end else if (i_stat.exp_lsb) begin
                    n_state = S_POW_MUL;
                end else begin
                    n_state = S_POW_SQR;
                end
            end
            S_POW_MUL:  n_state = S_POW_SQR;
            S_POW_SQR: begin
                // exponent shifts right on this step, so look one bit ahead
                if (i_stat.exp_next_zero) begin
                    n_state = S_AGE_FIN;
                end else if (i_stat.exp_next_lsb) begin
                    n_state = S_POW_MUL;
                end else begin
                    n_state = S_POW_SQR;
                end
            end
            S_AGE_FIN:   n_state = S_DONE_APP;
            S_DONE_APP:  n_state = S_IDLE;
            S_DONE_SKIP: n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_busy = (r_state != S_IDLE);
        case (r_state)
            S_IDLE:      o_op = i_start ? OP_LOAD : OP_NONE;
            S_ENC_MUL:   o_op = OP_ENC_MUL;
            S_ENC_ADD:   o_op = OP_ENC_ADD;
            S_TR_M1:     o_op = OP_TR_M1;
            S_TR_M2:     o_op = OP_TR_M2;
            S_TR_M3:     o_op = OP_TR_M3;
            S_TR_M4:     o_op = OP_TR_M4;
            S_TR_ADD:    o_op = OP_TR_ADD;
            S_AGE_PREP:  o_op = OP_AGE_PREP;
            S_DIV:       o_op = OP_DIV_STEP;
            S_POW_MUL:   o_op = OP_POW_MUL;
            S_POW_SQR:   o_op = OP_POW_SQR;
            S_AGE_FIN:   o_op = OP_AGE_FIN;
            S_DONE_APP:  o_op = OP_DONE_APP;
            S_DONE_SKIP: o_op = OP_DONE_SKIP;
            default:     o_op = OP_NONE;
        endcase
    end

`ifndef SYNTHESIS
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_start) |=> (r_state == S_DISPATCH))
        else $error("accepted item did not start the sequence");

    a_done_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE_APP || r_state == S_DONE_SKIP) |=> (r_state == S_IDLE))
        else $error("sequence did not return to idle after the result");
`endif

endmodule

`default_nettype wire

// ----- rtl/dpu_dp.sv -----
// datapath: probability and time state, configuration registers, one shared
// fixed-point multiplier and a radix-2 divider; uses dpu_pkg
`default_nettype none

module dpu_dp import dpu_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_op               i_op,
    input  logic [KIND_W-1:0]    i_kind,
    input  logic [TIME_W-1:0]    i_now,
    input  logic [P_W-1:0]       i_prob_ab,
    input  logic [P_W-1:0]       i_prob_bc,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output t_dp_stat             o_stat,
    output logic                 o_done,
    output logic [P_W-1:0]       o_probability,
    output logic                 o_applied
);

    // control / architectural state
    logic [P_W-1:0]     r_penc,  n_penc;
    logic [P_W-1:0]     r_beta,  n_beta;
    logic [P_W-1:0]     r_gamma, n_gamma;
    logic [KAPPA_W-1:0] r_kappa, n_kappa;
    logic [P_W-1:0]     r_prob,  n_prob;
    logic [TIME_W-1:0]  r_last,  n_last;
    logic               r_done,  n_done;

    // working registers
    logic [KIND_W-1:0]  r_kind,  n_kind;
    logic [TIME_W-1:0]  r_now,   n_now;
    logic [P_W-1:0]     r_ab,    n_ab;
    logic [P_W-1:0]     r_bc,    n_bc;
    logic [P_W-1:0]     r_acc,   n_acc;
    logic [P_W-1:0]     r_base,  n_base;
    logic [UNITS_W-1:0] r_quo,   n_quo;
    logic [KAPPA_W-1:0] r_rem,   n_rem;
    logic [CNT_W-1:0]   r_cnt,   n_cnt;
    logic [P_W-1:0]     r_out_prob, n_out_prob;
    logic               r_applied,  n_applied;

    logic [P_W-1:0]     enc, bt, gm;
    logic [P_W-1:0]     mul_a, mul_b, mul_res;
    logic [2*P_W-1:0]   mul_full;
    logic [P_W:0]       sum;
    logic [P_W-1:0]     sum_sat;
    logic [TIME_W-1:0]  diff;
    logic [UNITS_W-1:0] diff_ms;
    logic [KAPPA_W:0]   rem_sh, rem_sub;
    logic               rem_ge;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_penc  <= PENC_RST;
            r_beta  <= BETA_RST;
            r_gamma <= GAMMA_RST;
            r_kappa <= KAPPA_RST;
            r_prob  <= '0;
            r_last  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_penc  <= n_penc;
            r_beta  <= n_beta;
            r_gamma <= n_gamma;
            r_kappa <= n_kappa;
            r_prob  <= n_prob;
            r_last  <= n_last;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_now      <= n_now;
        r_ab       <= n_ab;
        r_bc       <= n_bc;
        r_acc      <= n_acc;
        r_base     <= n_base;
        r_quo      <= n_quo;
        r_rem      <= n_rem;
        r_cnt      <= n_cnt;
        r_out_prob <= n_out_prob;
        r_applied  <= n_applied;
    end

    // factors above one are used as one
    assign enc = sat_one(r_penc);
    assign bt  = sat_one(r_beta);
    assign gm  = sat_one(r_gamma);

    // shared multiplier operand select
    always_comb begin
        case (i_op)
            OP_ENC_MUL: begin mul_a = ONE - r_prob; mul_b = enc;     end
            OP_TR_M1:   begin mul_a = ONE - bt;     mul_b = r_ab;    end
            OP_TR_M2:   begin mul_a = r_acc;        mul_b = r_bc;    end
            OP_TR_M3:   begin mul_a = r_acc;        mul_b = enc;     end
            OP_TR_M4:   begin mul_a = r_prob;       mul_b = bt;      end
            OP_POW_MUL: begin mul_a = r_acc;        mul_b = r_base;  end
            OP_POW_SQR: begin mul_a = r_base;       mul_b = r_base;  end
            OP_AGE_FIN: begin mul_a = r_prob;       mul_b = r_acc;   end
            default:    begin mul_a = '0;           mul_b = '0;      end
        endcase
    end

    assign mul_full = mul_a * mul_b;
    assign mul_res  = mul_full[FRAC_BITS +: P_W];

    assign sum     = (i_op == OP_ENC_ADD) ? ({1'b0, r_prob} + {1'b0, r_acc})
                                          : ({1'b0, r_base} + {1'b0, r_acc});
    assign sum_sat = (sum > {1'b0, ONE}) ? ONE : sum[P_W-1:0];

    // elapsed milliseconds, time difference wraps
    assign diff    = r_now - r_last;
    assign diff_ms = {{MS_W{1'b0}}, diff} * {{TIME_W{1'b0}}, MS_PER_S};

    // restoring division, one quotient bit per step
    assign rem_sh  = {r_rem, r_quo[UNITS_W-1]};
    assign rem_ge  = (rem_sh >= {1'b0, r_kappa});
    assign rem_sub = rem_sh - {1'b0, r_kappa};

    always_comb begin
        n_penc     = r_penc;
        n_beta     = r_beta;
        n_gamma    = r_gamma;
        n_kappa    = r_kappa;
        n_prob     = r_prob;
        n_last     = r_last;
        n_done     = 1'b0;
        n_kind     = r_kind;
        n_now      = r_now;
        n_ab       = r_ab;
        n_bc       = r_bc;
        n_acc      = r_acc;
        n_base     = r_base;
        n_quo      = r_quo;
        n_rem      = r_rem;
        n_cnt      = r_cnt;
        n_out_prob = r_out_prob;
        n_applied  = r_applied;

        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_P_ENC: n_penc  = i_cfg_data;
                CFG_BETA:  n_beta  = i_cfg_data;
                CFG_GAMMA: n_gamma = i_cfg_data;
                CFG_KAPPA: n_kappa = i_cfg_data[KAPPA_W-1:0];
                default:   n_penc  = r_penc;
            endcase
        end

        case (i_op)
            OP_LOAD: begin
                n_kind = i_kind;
                n_now  = i_now;
                n_ab   = i_prob_ab;
                n_bc   = i_prob_bc;
            end
            OP_ENC_MUL, OP_TR_M1, OP_TR_M2, OP_TR_M3, OP_POW_MUL: begin
                n_acc = mul_res;
            end
            OP_TR_M4: begin
                n_base = mul_res;
            end
            OP_ENC_ADD, OP_TR_ADD: begin
                n_prob = sum_sat;
            end
            OP_AGE_PREP: begin
                n_quo  = (r_kappa == '0) ? '0 : diff_ms;
                n_rem  = '0;
                n_cnt  = '0;
                n_acc  = ONE;
                n_base = gm;
            end
            OP_DIV_STEP: begin
                n_rem = rem_ge ? rem_sub[KAPPA_W-1:0] : rem_sh[KAPPA_W-1:0];
                n_quo = {r_quo[UNITS_W-2:0], rem_ge};
                n_cnt = r_cnt + CNT_W'(1);
            end
            OP_POW_SQR: begin
                n_base = mul_res;
                n_quo  = {1'b0, r_quo[UNITS_W-1:1]};
            end
            OP_AGE_FIN: begin
                // a power of one leaves the probability as it is
                n_prob = sat_one(mul_res);
            end
            OP_DONE_APP: begin
                n_last     = r_now;
                n_done     = 1'b1;
                n_out_prob = r_prob;
                n_applied  = 1'b1;
            end
            OP_DONE_SKIP: begin
                n_done     = 1'b1;
                n_out_prob = r_prob;
                n_applied  = 1'b0;
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    always_comb begin
        o_stat.kind          = r_kind;
        o_stat.tr_ok         = (r_ab <= ONE) && (r_bc <= ONE) && (r_prob <= r_bc);
        o_stat.kappa_zero    = (r_kappa == '0);
        o_stat.div_last      = (r_cnt == CNT_W'(UNITS_W - 1));
        o_stat.exp_zero      = (r_quo == '0);
        o_stat.exp_lsb       = r_quo[0];
        o_stat.exp_next_zero = (r_quo[UNITS_W-1:1] == '0);
        o_stat.exp_next_lsb  = r_quo[1];
    end

    assign o_done        = r_done;
    assign o_probability = r_out_prob;
    assign o_applied     = r_applied;

`ifndef SYNTHESIS
    a_prob_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prob <= ONE)
        else $error("probability left the unit range");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("result strobe held for more than one cycle");

    a_skip_keeps_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && !r_applied) |-> $stable(r_last))
        else $error("skipped update changed the last update time");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_DIV_STEP) |-> (r_cnt < CNT_W'(UNITS_W)))
        else $error("divider ran past its step count");
`endif

endmodule

`default_nettype wire

// ----- tb/delivery_predictability_update_core_tb.sv -----
`timescale 1ns / 1ps
// self-checking testbench for delivery_predictability_update_core: directed and random
// updates under several factor settings, results checked against a local predictor
// depends on dpu_pkg and the core rtl only

module delivery_predictability_update_core_tb;
    import dpu_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = KIND_W'(3);
    localparam int N_PHASES        = 7;
    localparam int ITEMS_PER_PHASE = 57;
    localparam int TAIL_CYCLES     = 200;
    localparam int STALL_LIMIT     = 4000;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TIME_W-1:0] now;
        logic [P_W-1:0]    ab;
        logic [P_W-1:0]    bc;
    } t_dp_item;

    typedef struct packed {
        logic [P_W-1:0] probability;
        logic           applied;
    } t_dp_result;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 start      = 1'b0;
    logic                 busy;
    logic [KIND_W-1:0]    i_kind     = '0;
    logic [TIME_W-1:0]    i_now      = '0;
    logic [P_W-1:0]       i_prob_ab  = '0;
    logic [P_W-1:0]       i_prob_bc  = '0;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 o_done;
    logic [P_W-1:0]       o_probability;
    logic                 o_applied;

    // predictor state and factor copies
    logic [P_W-1:0]     p_now       = '0;
    logic [TIME_W-1:0]  last_update = '0;
    logic [P_W-1:0]     f_enc       = PENC_RST;
    logic [P_W-1:0]     f_beta      = BETA_RST;
    logic [P_W-1:0]     f_gamma     = GAMMA_RST;
    logic [KAPPA_W-1:0] kappa_ms    = KAPPA_RST;

    t_dp_item   pending_updates[$];
    t_dp_result expected_probs[$];
    t_dp_item   cur_update;

    logic [TIME_W-1:0] gen_clock = 32'd200;
    int burst_left  = 1;
    int gap_left    = 0;
    bit drain_hold  = 1'b0;
    int idle_cycles = 0;
    int n_errors    = 0;
    int n_checked   = 0;
    int n_skipped   = 0;
    int n_kind[4]   = '{default: 0};

    delivery_predictability_update_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_kind        (i_kind),
        .i_now         (i_now),
        .i_prob_ab     (i_prob_ab),
        .i_prob_bc     (i_prob_bc),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_done        (o_done),
        .o_probability (o_probability),
        .o_applied     (o_applied)
    );

    always #6 i_clk = ~i_clk;

    function automatic logic [P_W-1:0] cap_unit(input logic [P_W:0] v);
        return (v > ONE) ? ONE : v[P_W-1:0];
    endfunction

    // truncated fixed-point product, both operands at most one
    function automatic logic [P_W-1:0] fx_prod(input logic [P_W-1:0] a,
                                               input logic [P_W-1:0] b);
        logic [2*P_W-1:0] full;
        full = a * b;
        return P_W'(full >> FRAC_BITS);
    endfunction

    function automatic t_dp_result predict_update(input t_dp_item u);
        t_dp_result         res;
        logic [P_W-1:0]     enc;
        logic [P_W-1:0]     bt;
        logic [P_W-1:0]     gm;
        logic [P_W-1:0]     base;
        logic [P_W-1:0]     acc;
        logic [P_W-1:0]     t;
        logic [P_W:0]       sum;
        logic [TIME_W-1:0]  elapsed;
        logic [UNITS_W-1:0] units;
        int                 b;
        enc = cap_unit(f_enc);
        bt  = cap_unit(f_beta);
        gm  = cap_unit(f_gamma);
        res.applied = 1'b0;
        case (u.kind)
            KIND_ENC: begin
                sum = p_now + fx_prod(ONE - p_now, enc);
                p_now = cap_unit(sum);
                res.applied = 1'b1;
            end
            KIND_TRANS: begin
                if (u.ab <= ONE && u.bc <= ONE && p_now <= u.bc) begin
                    t = fx_prod(fx_prod(fx_prod(ONE - bt, u.ab), u.bc), enc);
                    sum = fx_prod(p_now, bt) + t;
                    p_now = cap_unit(sum);
                    res.applied = 1'b1;
                end
            end
            KIND_AGE: begin
                units = '0;
                if (kappa_ms != '0) begin
                    elapsed = u.now - last_update;
                    units = (UNITS_W'(elapsed) * UNITS_W'(MS_PER_S)) / UNITS_W'(kappa_ms);
                end
                if (units != '0) begin
                    // square and multiply, low exponent bit first
                    acc  = ONE;
                    base = gm;
                    for (b = 0; b < UNITS_W && units != '0; b++) begin
                        if (units[0]) acc = fx_prod(acc, base);
                        base  = fx_prod(base, base);
                        units = units >> 1;
                    end
                    p_now = fx_prod(p_now, acc);
                end
                res.applied = 1'b1;
            end
            default: ;
        endcase
        if (res.applied) last_update = u.now;
        res.probability = p_now;
        return res;
    endfunction

    // sender: bursts of items, random gaps, now and then a pause until drained
    always @(posedge i_clk) begin
        bit         accepted;
        t_dp_result res;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            accepted = start && !busy;
            if (accepted) begin
                res = predict_update(cur_update);
                expected_probs.push_back(res);
                n_kind[cur_update.kind]++;
                if (cur_update.kind == KIND_TRANS && !res.applied) n_skipped++;
            end
            if (!start || accepted) begin
                if (drain_hold && (accepted || busy)) begin
                    start <= 1'b0;
                end else begin
                    drain_hold = 1'b0;
                    if (gap_left > 0) begin
                        gap_left--;
                        start <= 1'b0;
                    end else if (pending_updates.size() == 0) begin
                        start <= 1'b0;
                    end else begin
                        cur_update = pending_updates.pop_front();
                        i_kind    <= cur_update.kind;
                        i_now     <= cur_update.now;
                        i_prob_ab <= cur_update.ab;
                        i_prob_bc <= cur_update.bc;
                        start     <= 1'b1;
                        burst_left--;
                        if (burst_left == 0) begin
                            burst_left = $urandom_range(1, 24);
                            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                            drain_hold = ($urandom_range(0, 9) == 0);
                        end
                    end
                end
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_dp_result exp_res;
        if (i_rst_n && o_done) begin
            if (expected_probs.size() == 0) begin
                $error("result with no item outstanding: probability %0d, applied %0d",
                       o_probability, o_applied);
                n_errors++;
            end else begin
                exp_res = expected_probs.pop_front();
                n_checked++;
                if (o_probability !== exp_res.probability) begin
                    $error("probability mismatch: expected %0d, got %0d",
                           exp_res.probability, o_probability);
                    n_errors++;
                end
                if (o_applied !== exp_res.applied) begin
                    $error("applied mismatch: expected %0d, got %0d",
                           exp_res.applied, o_applied);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [P_W-1:0] rand_prob();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) return ONE;
        if (r < 35) return P_W'($urandom_range(ONE + 1, {P_W{1'b1}}));
        if (r < 40) return '0;
        return P_W'($urandom_range(0, ONE));
    endfunction

    task automatic add_update(input logic [KIND_W-1:0] kind, input logic [TIME_W-1:0] now,
                              input logic [P_W-1:0] ab, input logic [P_W-1:0] bc);
        t_dp_item u;
        u.kind = kind;
        u.now  = now;
        u.ab   = ab;
        u.bc   = bc;
        pending_updates.push_back(u);
    endtask

    task automatic queue_random(input int n);
        int k;
        int r;
        logic [KIND_W-1:0] kind;
        for (k = 0; k < n; k++) begin
            // time mostly creeps forward, sometimes jumps anywhere
            if ($urandom_range(0, 99) < 5) gen_clock = $urandom;
            else gen_clock += $urandom_range(0, 4);
            r = $urandom_range(0, 99);
            if (r < 33) kind = KIND_ENC;
            else if (r < 63) kind = KIND_TRANS;
            else if (r < 93) kind = KIND_AGE;
            else kind = KIND_UNUSED;
            add_update(kind, gen_clock, rand_prob(), rand_prob());
        end
    endtask

    task automatic write_factor(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_P_ENC: f_enc    = data;
            CFG_BETA:  f_beta   = data;
            CFG_GAMMA: f_gamma  = data;
            CFG_KAPPA: kappa_ms = data[KAPPA_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_factors(input int ph);
        logic [CFG_W-1:0] all_set;
        all_set = '1;
        case (ph)
            1: begin
                write_factor(CFG_P_ENC, CFG_W'($urandom_range(0, ONE)));
                write_factor(CFG_BETA,  '0);
                write_factor(CFG_GAMMA, '0);
                write_factor(CFG_KAPPA, '0);
            end
            2: begin
                write_factor(CFG_P_ENC, ONE);
                write_factor(CFG_BETA,  ONE);
                write_factor(CFG_GAMMA, ONE);
                write_factor(CFG_KAPPA, CFG_W'(1));
            end
            3: begin
                // factors above one act as one, kappa takes its low bits
                write_factor(CFG_P_ENC, all_set);
                write_factor(CFG_BETA,  all_set);
                write_factor(CFG_GAMMA, all_set);
                write_factor(CFG_KAPPA, all_set);
            end
            5: begin
                write_factor(CFG_P_ENC, '0);
                write_factor(CFG_BETA,  CFG_W'($urandom_range(0, ONE)));
                write_factor(CFG_GAMMA, CFG_W'($urandom_range(50000, ONE)));
                write_factor(CFG_KAPPA, CFG_W'($urandom_range(1, 2000)));
            end
            6: begin
                write_factor(CFG_P_ENC, PENC_RST);
                write_factor(CFG_BETA,  BETA_RST);
                write_factor(CFG_GAMMA, GAMMA_RST);
                write_factor(CFG_KAPPA, KAPPA_RST);
            end
            default: begin
                write_factor(CFG_P_ENC, CFG_W'($urandom_range(0, ONE)));
                write_factor(CFG_BETA,  CFG_W'($urandom_range(0, ONE)));
                write_factor(CFG_GAMMA, CFG_W'($urandom_range(50000, ONE)));
                write_factor(CFG_KAPPA, CFG_W'($urandom_range(1, 2000)));
            end
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // every item gives a result, so an empty store with the port idle means the core is idle
    task automatic wait_idle();
        while (pending_updates.size() != 0 || start || busy || expected_probs.size() != 0)
            @(negedge i_clk);
    endtask

    initial begin
        int ph;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part under the reset factors
        add_update(KIND_AGE,    32'd0, '0, '0);
        add_update(KIND_TRANS,  32'd1, ONE, '0);
        add_update(KIND_ENC,    32'd5, '0, '0);
        add_update(KIND_ENC,    32'd6, '0, '0);
        add_update(KIND_TRANS,  32'd7, ONE, ONE);
        add_update(KIND_TRANS,  32'd8, '0, '0);
        add_update(KIND_TRANS,  32'd8, ONE + 1, ONE);
        add_update(KIND_TRANS,  32'd8, ONE, '1);
        add_update(KIND_UNUSED, '1, '1, '1);
        add_update(KIND_AGE,    32'd9, '0, '0);
        add_update(KIND_AGE,    32'd9, '0, '0);
        add_update(KIND_ENC,    32'd10, '0, '0);
        add_update(KIND_AGE,    '1, '0, '0);
        add_update(KIND_ENC,    32'd0, '0, '0);
        add_update(KIND_ENC,    32'd1, '0, '0);
        add_update(KIND_AGE,    32'd0, '0, '0);
        add_update(KIND_ENC,    32'd100, '0, '0);
        add_update(KIND_TRANS,  32'd101, ONE - 1, ONE);
        add_update(KIND_AGE,    32'd102, '0, '0);
        add_update(KIND_UNUSED, 32'd0, '0, '0);
        queue_random(ITEMS_PER_PHASE);

        for (ph = 1; ph < N_PHASES; ph++) begin
            wait_idle();
            set_factors(ph);
            queue_random(ITEMS_PER_PHASE);
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("run covered %0d encounter, %0d transitive (%0d skipped), %0d age, %0d unused",
                 n_kind[KIND_ENC], n_kind[KIND_TRANS], n_skipped, n_kind[KIND_AGE],
                 n_kind[KIND_UNUSED]);
        $display("%0d results compared over %0d factor settings, %0d mismatches",
                 n_checked, N_PHASES, n_errors);
        if (n_errors == 0 && expected_probs.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
